FILE: rtl/core/kvlt_pkg.sv
// Package of shared constants and types for the key/value line tokenizer.
package kvlt_pkg;

  localparam int unsigned MaxText  = 131072;
  localparam int unsigned CharBits = 16;
  localparam int unsigned ChW      = 16;
  localparam int unsigned PosW     = 17;

  localparam int unsigned PosCapInt =
      ((MaxText - 1) < 131071) ? (MaxText - 1) : 131071;
  localparam logic [PosW-1:0] PosCap = PosW'(PosCapInt);

  localparam int unsigned FifoAw    = 1;
  localparam int unsigned FifoDepth = 2 ** FifoAw;

  typedef enum logic [2:0] {
    ClsOther,
    ClsAlnum,
    ClsBlank,
    ClsEq,
    ClsEol
  } char_class_e;

  typedef struct packed {
    char_class_e     cls;
    logic [PosW-1:0] idx;
    logic            trunc;
    logic            last;
  } kvlt_word_t;

endpackage

FILE: rtl/core/kvlt_front.sv
// Front end: accepts characters, classifies them and tags them with their position.
module kvlt_front import kvlt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [ChW-1:0]  ch_i,
  input  logic            last_char_i,
  output logic            word_valid_o,
  input  logic            word_ready_i,
  output kvlt_word_t      word_o
);

  localparam logic [CharBits-1:0] ChEqual = CharBits'(8'h3D);
  localparam logic [CharBits-1:0] ChSpace = CharBits'(8'h20);
  localparam logic [CharBits-1:0] ChTab   = CharBits'(8'h09);
  localparam logic [CharBits-1:0] ChCr    = CharBits'(8'h0D);
  localparam logic [CharBits-1:0] ChLf    = CharBits'(8'h0A);
  localparam logic [CharBits-1:0] Ch0     = CharBits'(8'h30);
  localparam logic [CharBits-1:0] Ch9     = CharBits'(8'h39);
  localparam logic [CharBits-1:0] ChUA    = CharBits'(8'h41);
  localparam logic [CharBits-1:0] ChUZ    = CharBits'(8'h5A);
  localparam logic [CharBits-1:0] ChLa    = CharBits'(8'h61);
  localparam logic [CharBits-1:0] ChLz    = CharBits'(8'h7A);

  logic [PosW-1:0]     pos_q, pos_d;
  logic                full_q, full_d;
  logic                ovf_q, ovf_d;
  logic [CharBits-1:0] c;
  logic                accept;
  logic                trunc;
  char_class_e         cls;

  assign c      = ch_i[CharBits-1:0];
  assign accept = in_valid_i & word_ready_i;
  assign trunc  = ovf_q | full_q;

  always_comb begin
    if (c == ChCr || c == ChLf) begin
      cls = ClsEol;
    end else if (c == ChSpace || c == ChTab) begin
      cls = ClsBlank;
    end else if (c == ChEqual) begin
      cls = ClsEq;
    end else if ((c >= Ch0 && c <= Ch9) || (c >= ChUA && c <= ChUZ) ||
                 (c >= ChLa && c <= ChLz)) begin
      cls = ClsAlnum;
    end else begin
      cls = ClsOther;
    end
  end

  assign in_ready_o   = word_ready_i;
  assign word_valid_o = in_valid_i;
  assign word_o       = '{cls: cls, idx: pos_q, trunc: trunc, last: last_char_i};

  // Saturate the position; restart numbering after the end of a text.
  always_comb begin
    pos_d  = pos_q;
    full_d = full_q;
    ovf_d  = ovf_q;
    if (accept) begin
      if (last_char_i) begin
        pos_d  = '0;
        full_d = 1'b0;
        ovf_d  = 1'b0;
      end else begin
        ovf_d = trunc;
        if (pos_q >= PosCap) begin
          full_d = 1'b1;
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      full_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      full_q <= full_d;
      ovf_q  <= ovf_d;
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
      accept && last_char_i |=> pos_q == '0 && !ovf_q && !full_q)
    else $error("position not restarted after end of text");

  a_pos_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
      pos_q <= PosCap)
    else $error("position beyond cap");

endmodule

FILE: rtl/core/kvlt_fifo.sv
// Short queue that decouples the front end from the back end.
module kvlt_fifo import kvlt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  kvlt_word_t push_word_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output kvlt_word_t pop_word_o
);

  kvlt_word_t          mem_q [FifoDepth];
  logic [FifoAw-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [FifoAw:0]     cnt_q, cnt_d;
  logic                push, pop;

  assign push_ready_o = (cnt_q != (FifoAw+1)'(FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_word_o   = mem_q[rd_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_d  = push ? wr_q + FifoAw'(1) : wr_q;
    rd_d  = pop ? rd_q + FifoAw'(1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + (FifoAw+1)'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - (FifoAw+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cnt_q <= (FifoAw+1)'(FifoDepth))
    else $error("queue count overflow");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
      push && !pop |=> cnt_q == $past(cnt_q) + (FifoAw+1)'(1))
    else $error("queue count did not advance on push");

endmodule

FILE: rtl/core/kvlt_back.sv
// Back end: tracks line state, picks the splitter and registers the result.
module kvlt_back import kvlt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            word_valid_i,
  output logic            word_ready_o,
  input  kvlt_word_t      word_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PosW-1:0] key_start_o,
  output logic [PosW-1:0] key_len_o,
  output logic [PosW-1:0] value_start_o,
  output logic [PosW-1:0] value_len_o,
  output logic            truncated_o
);

  typedef struct packed {
    logic            in_line;
    logic            first_alnum;
    logic            recent_eq;
    logic [3:0]      flags;      // last valid, last has value, prev valid, prev has value
    logic [PosW-1:0] line_start;
    logic [PosW-1:0] last_nb;
    logic [PosW-1:0] last_key_end;
    logic [PosW-1:0] last_val_first;
    logic [PosW-1:0] prev_key_end;
    logic [PosW-1:0] prev_val_first;
  } line_t;

  line_t           line_q, line_d, upd, fin;
  logic            pop, is_eol, blank, do_finish, ok;
  logic [PosW-1:0] key_end, val_first;
  logic            out_valid_q, out_valid_d;
  logic [PosW-1:0] key_start_q, key_len_q, value_start_q, value_len_q;
  logic            trunc_q;

  assign word_ready_o = !out_valid_q || out_ready_i;
  assign pop          = word_valid_i & word_ready_o;
  assign is_eol       = (word_i.cls == ClsEol);
  assign blank        = (word_i.cls == ClsBlank);

  // Line state after a non line-end character.
  always_comb begin
    upd = line_q;
    if (!line_q.in_line) begin
      upd             = '0;
      upd.in_line     = 1'b1;
      upd.first_alnum = (word_i.cls == ClsAlnum);
      upd.line_start  = word_i.idx;
      upd.last_nb     = word_i.idx;
      upd.last_key_end   = line_q.last_key_end;
      upd.last_val_first = line_q.last_val_first;
      upd.prev_key_end   = line_q.prev_key_end;
      upd.prev_val_first = line_q.prev_val_first;
    end else begin
      if (!blank) begin
        if (upd.flags[0] && !upd.flags[1]) begin
          upd.last_val_first = word_i.idx;
          upd.flags[1]       = 1'b1;
        end
        if (upd.flags[2] && !upd.flags[3]) begin
          upd.prev_val_first = word_i.idx;
          upd.flags[3]       = 1'b1;
        end
      end
      if (word_i.cls == ClsEq) begin
        upd.prev_key_end   = upd.last_key_end;
        upd.prev_val_first = upd.last_val_first;
        upd.flags          = {upd.flags[1:0], 2'b01};
        upd.last_key_end   = line_q.last_nb;
        upd.last_val_first = '0;
      end
      if (!blank) begin
        upd.last_nb = word_i.idx;
      end
      upd.recent_eq = (word_i.cls == ClsEq);
    end
  end

  // A line ends on CR/LF (old state) or on the final character (updated state).
  assign fin       = is_eol ? line_q : upd;
  assign do_finish = is_eol ? line_q.in_line : word_i.last;

  always_comb begin
    ok        = 1'b0;
    key_end   = '0;
    val_first = '0;
    if (fin.flags[0] && !fin.recent_eq) begin
      ok        = fin.flags[1];
      key_end   = fin.last_key_end;
      val_first = fin.last_val_first;
    end else if (fin.flags[2]) begin
      ok        = fin.flags[3];
      key_end   = fin.prev_key_end;
      val_first = fin.prev_val_first;
    end
    ok = ok & fin.first_alnum;
  end

  always_comb begin
    line_d = line_q;
    if (pop) begin
      if (is_eol || word_i.last) begin
        line_d = '0;
      end else begin
        line_d = upd;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop && do_finish && ok) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && do_finish && ok) begin
      key_start_q   <= fin.line_start;
      key_len_q     <= key_end - fin.line_start + PosW'(1);
      value_start_q <= val_first;
      value_len_q   <= fin.last_nb - val_first + PosW'(1);
      trunc_q       <= word_i.trunc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign key_start_o   = key_start_q;
  assign key_len_o     = key_len_q;
  assign value_start_o = value_start_q;
  assign value_len_o   = value_len_q;
  assign truncated_o   = trunc_q;

  a_lens_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> key_len_o != '0 && value_len_o != '0)
    else $error("empty key or value emitted");

  a_line_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
      pop && (is_eol || word_i.last) |=> !line_q.in_line && line_q.flags == '0)
    else $error("line state not cleared at line end");

endmodule

FILE: rtl/core/key_value_line_tokenizer.sv
// A result is registered at the edge that pops its line-ending word from the
// queue, which that word enters at the edge where it is accepted.
// Throughput: one character word per cycle, sustained, while results are taken;
// the two-entry queue and the output register let either side stall alone.
// Reset (rst_ni low, asynchronous): position, line state, queue and output valid
// clear; a new text starts at position zero.
module key_value_line_tokenizer import kvlt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [ChW-1:0]  ch_i,
  input  logic            last_char_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PosW-1:0] key_start_o,
  output logic [PosW-1:0] key_len_o,
  output logic [PosW-1:0] value_start_o,
  output logic [PosW-1:0] value_len_o,
  output logic            truncated_o
);

  // Front to queue: classified word tagged with its position and overflow flag.
  logic       f_valid, f_ready;
  kvlt_word_t f_word;

  // Queue to back end.
  logic       b_valid, b_ready;
  kvlt_word_t b_word;

  // Classify each character and number it; saturate the position counter.
  kvlt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ch_i         (ch_i),
    .last_char_i  (last_char_i),
    .word_valid_o (f_valid),
    .word_ready_i (f_ready),
    .word_o       (f_word)
  );

  // Hold words while the back end waits on a stalled result.
  kvlt_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_word_i  (f_word),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_word_o   (b_word)
  );

  // Track the splitter candidates of the current line and emit accepted lines.
  kvlt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .word_valid_i  (b_valid),
    .word_ready_o  (b_ready),
    .word_i        (b_word),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .key_start_o   (key_start_o),
    .key_len_o     (key_len_o),
    .value_start_o (value_start_o),
    .value_len_o   (value_len_o),
    .truncated_o   (truncated_o)
  );

endmodule

FILE: tb/sv/tb_key_value_line_tokenizer.sv
// Testbench for key_value_line_tokenizer: directed and random texts against a line parser model.
`timescale 1ns / 100ps

module tb_key_value_line_tokenizer;
  import kvlt_pkg::*;

  // Character codes the parser reacts to.
  localparam logic [ChW-1:0] ChCr    = 16'h000D;
  localparam logic [ChW-1:0] ChLf    = 16'h000A;
  localparam logic [ChW-1:0] ChSpace = 16'h0020;
  localparam logic [ChW-1:0] ChTab   = 16'h0009;
  localparam logic [ChW-1:0] ChEq    = 16'h003D;
  localparam logic [ChW-1:0] ChDig0  = 16'h0030;
  localparam logic [ChW-1:0] ChDig9  = 16'h0039;
  localparam logic [ChW-1:0] ChUpA   = 16'h0041;
  localparam logic [ChW-1:0] ChUpZ   = 16'h005A;
  localparam logic [ChW-1:0] ChLoA   = 16'h0061;
  localparam logic [ChW-1:0] ChLoZ   = 16'h007A;
  localparam logic [ChW-1:0] CharMask = ChW'((64'd1 << CharBits) - 1);

  localparam int unsigned RandomChars = 1050;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 32;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           last;
  } char_word_t;

  typedef struct packed {
    logic [PosW-1:0] key_start;
    logic [PosW-1:0] key_len;
    logic [PosW-1:0] value_start;
    logic [PosW-1:0] value_len;
    logic            truncated;
  } kv_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic            in_valid = 1'b0;
  logic [ChW-1:0]  ch_d = '0;
  logic            last_d = 1'b0;
  logic            in_ready_o;
  logic            out_valid_o;
  logic            out_ready = 1'b0;
  logic [PosW-1:0] key_start_o;
  logic [PosW-1:0] key_len_o;
  logic [PosW-1:0] value_start_o;
  logic [PosW-1:0] value_len_o;
  logic            truncated_o;

  // Words waiting to be sent, and pairs the parser model says must come out.
  char_word_t  char_q[$];
  kv_pair_t    pair_expect_q[$];
  int unsigned gen_count = 0;
  int unsigned err_cnt = 0;

  key_value_line_tokenizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .ch_i          (ch_d),
    .last_char_i   (last_d),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .key_start_o   (key_start_o),
    .key_len_o     (key_len_o),
    .value_start_o (value_start_o),
    .value_len_o   (value_len_o),
    .truncated_o   (truncated_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Line parser model. Tracks the current line and the two most recent '='
  // splitter candidates; a line that ends in '=' falls back to the older one.
  // ---------------------------------------------------------------------------
  logic [PosW-1:0] text_pos;
  logic            pos_sat;       // saturation index already handed out
  logic            text_trunc;
  logic            line_open;
  logic [PosW-1:0] line_first;
  logic            line_alnum;
  logic [PosW-1:0] line_last_nb;
  logic            line_ends_eq;
  logic            cand_ok, cand_has_val, old_ok, old_has_val;
  logic [PosW-1:0] cand_key_end, cand_val_first, old_key_end, old_val_first;

  function automatic logic is_alnum_code(logic [ChW-1:0] c);
    return (c >= ChDig0 && c <= ChDig9) || (c >= ChUpA && c <= ChUpZ) ||
           (c >= ChLoA && c <= ChLoZ);
  endfunction

  function automatic void reset_line();
    line_open      = 1'b0;
    line_first     = '0;
    line_alnum     = 1'b0;
    line_last_nb   = '0;
    line_ends_eq   = 1'b0;
    cand_ok        = 1'b0;
    cand_has_val   = 1'b0;
    old_ok         = 1'b0;
    old_has_val    = 1'b0;
    cand_key_end   = '0;
    cand_val_first = '0;
    old_key_end    = '0;
    old_val_first  = '0;
  endfunction

  // Close the open line and queue its pair if the line is well formed.
  function automatic void close_line();
    logic            ok;
    logic [PosW-1:0] key_end;
    logic [PosW-1:0] val_first;
    ok        = 1'b0;
    key_end   = '0;
    val_first = '0;
    if (line_open) begin
      if (cand_ok && !line_ends_eq) begin
        ok        = cand_has_val;
        key_end   = cand_key_end;
        val_first = cand_val_first;
      end else if (old_ok) begin
        ok        = old_has_val;
        key_end   = old_key_end;
        val_first = old_val_first;
      end
      if (ok && line_alnum) begin
        pair_expect_q.push_back('{
          key_start:   line_first,
          key_len:     key_end - line_first + PosW'(1),
          value_start: val_first,
          value_len:   line_last_nb - val_first + PosW'(1),
          truncated:   text_trunc
        });
      end
    end
    reset_line();
  endfunction

  function automatic void reset_text();
    text_pos   = '0;
    pos_sat    = 1'b0;
    text_trunc = 1'b0;
    reset_line();
  endfunction

  // Advance the model by one accepted character word.
  function automatic void parse_char(logic [ChW-1:0] ch_raw, logic is_last);
    logic [ChW-1:0]  c;
    logic [PosW-1:0] idx;
    logic            blank;
    c   = ch_raw & CharMask;
    idx = text_pos;
    if (pos_sat) text_trunc = 1'b1;
    if (text_pos >= PosCap) pos_sat = 1'b1;
    else text_pos = text_pos + PosW'(1);

    if (c == ChCr || c == ChLf) begin
      close_line();
    end else if (!line_open) begin
      line_open    = 1'b1;
      line_first   = idx;
      line_alnum   = is_alnum_code(c);
      line_last_nb = idx;
      line_ends_eq = 1'b0;
      cand_ok      = 1'b0;
      cand_has_val = 1'b0;
      old_ok       = 1'b0;
      old_has_val  = 1'b0;
    end else begin
      blank = (c == ChSpace || c == ChTab);
      if (!blank) begin
        if (cand_ok && !cand_has_val) begin
          cand_val_first = idx;
          cand_has_val   = 1'b1;
        end
        if (old_ok && !old_has_val) begin
          old_val_first = idx;
          old_has_val   = 1'b1;
        end
      end
      if (c == ChEq) begin
        // Shift the latest candidate down and open a new one here.
        old_ok         = cand_ok;
        old_has_val    = cand_has_val;
        old_key_end    = cand_key_end;
        old_val_first  = cand_val_first;
        cand_ok        = 1'b1;
        cand_has_val   = 1'b0;
        cand_key_end   = line_last_nb;
        cand_val_first = '0;
      end
      if (!blank) line_last_nb = idx;
      line_ends_eq = (c == ChEq);
    end

    if (is_last) begin
      if (line_open) close_line();
      reset_text();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------
  function automatic void push_char(logic [ChW-1:0] c, logic is_last = 1'b0);
    char_q.push_back('{ch: c, last: is_last});
    gen_count++;
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) push_char({8'h00, s[i]});
  endfunction

  function automatic logic [ChW-1:0] rand_alnum();
    case ($urandom_range(0, 2))
      0:       return ChDig0 + ChW'($urandom_range(0, 9));
      1:       return ChUpA + ChW'($urandom_range(0, 25));
      default: return ChLoA + ChW'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [ChW-1:0] rand_blank();
    return $urandom_range(0, 1) ? ChSpace : ChTab;
  endfunction

  // Any character that does not end a line: printable ASCII, neighbors of the
  // letter and digit ranges, or a wide code unit.
  function automatic logic [ChW-1:0] rand_text_char();
    case ($urandom_range(0, 3))
      0:       return ChW'($urandom_range(16'h0021, 16'h007E));
      1:       return ChW'($urandom_range(16'h0100, 16'hFFFF));
      2: begin
        case ($urandom_range(0, 5))
          0:       return ChDig0 - ChW'(1);
          1:       return ChDig9 + ChW'(1);
          2:       return ChUpA - ChW'(1);
          3:       return ChUpZ + ChW'(1);
          4:       return ChLoA - ChW'(1);
          default: return ChLoZ + ChW'(1);
        endcase
      end
      default: return ChEq | 16'h0100;  // '=' in the low byte only
    endcase
  endfunction

  function automatic logic [ChW-1:0] rand_noise_char();
    case ($urandom_range(0, 5))
      0:       return ChW'($urandom_range(0, 16'hFFFF));
      1:       return ChEq;
      2:       return rand_blank();
      3:       return $urandom_range(0, 1) ? ChCr : ChLf;
      4:       return rand_alnum();
      default: return rand_text_char();
    endcase
  endfunction

  // Append one line; well-formed lines carry random content around a splitter.
  function automatic void add_line(logic good, logic may_end);
    int unsigned n;
    if (good) begin
      push_char(rand_alnum());
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 9))
          0:       push_char(rand_blank());
          1:       push_char(rand_text_char());
          default: push_char(rand_alnum());
        endcase
      end
      repeat ($urandom_range(0, 2)) push_char(rand_blank());
      push_char(ChEq);
      repeat ($urandom_range(0, 2)) push_char(rand_blank());
      push_char($urandom_range(0, 3) == 0 ? rand_text_char() : rand_alnum());
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 9))
          0, 1:    push_char(rand_blank());
          2:       push_char(ChEq);
          3:       push_char(rand_text_char());
          default: push_char(rand_alnum());
        endcase
      end
      repeat ($urandom_range(0, 2)) push_char(rand_blank());
      if ($urandom_range(0, 7) == 0) push_char(ChEq);
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) push_char(rand_noise_char());
    end

    if (may_end && $urandom_range(0, 5) == 0) begin
      // End the text, either on the line's last character or on a line break.
      if ($urandom_range(0, 1)) begin
        char_q[char_q.size() - 1].last = 1'b1;
      end else begin
        repeat ($urandom_range(0, 2)) push_char($urandom_range(0, 1) ? ChCr : ChLf);
        push_char($urandom_range(0, 1) ? ChCr : ChLf, 1'b1);
      end
    end else begin
      repeat ($urandom_range(1, 3)) push_char($urandom_range(0, 1) ? ChCr : ChLf);
    end
  endfunction

  task automatic report_error(string what, int unsigned want, int unsigned got);
    err_cnt++;
    if (err_cnt <= MaxReports) begin
      $display("ERROR %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned goal;
    reset_text();

    // Directed text: plain pair, '=' as first character, trimming with merged
    // CR LF, splitter as last character at end of text, extreme code units, empty value.
    push_str("a=b");
    push_char(ChCr);
    push_str("=y");
    push_char(ChLf);
    push_str("9 =");
    push_char(ChSpace);
    push_char(ChTab);
    push_str("v ");
    push_char(ChTab);
    push_char(ChCr);
    push_char(ChLf);
    push_str("z=a");
    push_char(ChEq, 1'b1);
    push_str("A");
    push_char(16'hFFFF);
    push_char(ChEq);
    push_char(16'h0000);
    push_char(16'h013D);
    push_char(ChLf);
    push_str("k= ");
    push_char(ChLf);
    push_char(ChCr, 1'b1);  // empty line ends the text

    // Random texts, mostly well-formed lines with some noise lines.
    goal = gen_count + RandomChars;
    while (gen_count < goal) add_line($urandom_range(0, 9) < 7, 1'b1);
    push_char(ChLf, 1'b1);

    // Six more well-formed lines that may end texts; each new text restarts at position zero.
    repeat (6) add_line(1'b1, 1'b1);
    push_char(ChLf, 1'b1);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the queue to drain and every pair to come back.
    while (char_q.size() != 0 || in_valid || pair_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: send words in bursts of random length separated by random gaps.
  // Feed the model at the edge where a word is accepted.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin : driver
    char_word_t w;
    if (rst_ni) begin
      if (in_valid && in_ready_o) parse_char(ch_d, last_d);
      // Hold the current word until it is taken; otherwise pick the next one.
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0 || char_q.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          w = char_q.pop_front();
          in_valid <= 1'b1;
          ch_d     <= w.ch;
          last_d   <= w.last;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                     : $urandom_range(1, 24);
          end
          burst_left--;
          if (burst_left == 0) begin
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(4, 20);
              default: gap_left = $urandom_range(1, 3);
            endcase
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take pairs under a rotating stall pattern and check each field
  // against the oldest expected pair.
  // ---------------------------------------------------------------------------
  logic [7:0] stall_pat = 8'hFF;
  logic [7:0] stall_timer = '0;

  always @(posedge clk_i) begin : monitor
    kv_pair_t got;
    kv_pair_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        got = '{key_start_o, key_len_o, value_start_o, value_len_o, truncated_o};
        if (pair_expect_q.size() == 0) begin
          report_error("pair with no expectation, key_start", 0, got.key_start);
        end else begin
          want = pair_expect_q.pop_front();
          if (got.key_start !== want.key_start)
            report_error("key_start", want.key_start, got.key_start);
          if (got.key_len !== want.key_len)
            report_error("key_len", want.key_len, got.key_len);
          if (got.value_start !== want.value_start)
            report_error("value_start", want.value_start, got.value_start);
          if (got.value_len !== want.value_len)
            report_error("value_len", want.value_len, got.value_len);
          if (got.truncated !== want.truncated)
            report_error("truncated", want.truncated, got.truncated);
        end
      end

      // Reload the pattern whenever the 8-bit stall timer wraps: always ready,
      // random, or heavy stall. Bit 0 is set in every pattern, so ready always returns.
      stall_timer = stall_timer + 8'(1);
      if (stall_timer == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pat = 8'hFF;
          1:       stall_pat = 8'($urandom) | 8'h01;
          default: stall_pat = 8'h01;
        endcase
      end else begin
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
      out_ready <= stall_pat[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves a word for too long.
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

FILE: filelist.f
rtl/core/kvlt_pkg.sv
rtl/core/kvlt_front.sv
rtl/core/kvlt_fifo.sv
rtl/core/kvlt_back.sv
rtl/core/key_value_line_tokenizer.sv
tb/sv/tb_key_value_line_tokenizer.sv
